// ----- rtl/ipss_pkg.sv -----
// ----------------------------------------------------------------------------
// ipss_pkg: shared types and constants of the IMU SPI poll sequencer
// Holds the sensor register addresses, the result kind codes, the phase
// encoding and the command word that goes from the front end to the back end.
// ----------------------------------------------------------------------------
package ipss_pkg;

	// Sensor register map and SPI framing.
	localparam logic [7:0] READ_FLAG      = 8'h80;
	localparam logic [7:0] GYRO_CFG_REG   = 8'h1B;
	localparam logic [7:0] ACCEL_CFG_REG  = 8'h1C;
	localparam logic [7:0] ACCEL_DATA_REG = 8'h3B;
	localparam logic [7:0] GYRO_DATA_REG  = 8'h43;
	localparam logic [7:0] FILL_BYTE      = 8'h00;

	// Configuration register indexes.
	localparam logic CFG_ACCEL_SCALE = 1'b0;
	localparam logic CFG_GYRO_SCALE  = 1'b1;

	// Input operation codes.
	localparam logic OP_START = 1'b0;
	localparam logic OP_BYTE  = 1'b1;

	// Reply counting.
	localparam int          REPLY_BYTES  = 6;
	localparam logic [2:0]  WRITE_WAIT   = 3'd2;
	localparam logic [2:0]  REPLY_FULL   = 3'd7;
	localparam logic [2:0]  READ_LAST    = 3'd6;
	localparam logic [2:0]  WRITE_LAST   = 3'd1;

	// Command queue geometry.
	localparam int CMD_FIFO_DEPTH = 2;
	localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
	localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_TX    = 2'd0,
		KIND_ACCEL = 2'd1,
		KIND_GYRO  = 2'd2
	} ipss_kind_t;

	typedef enum logic [4:0] {
		PH_INIT_ACC  = 5'b00001,
		PH_INIT_GYRO = 5'b00010,
		PH_POLL_ACC  = 5'b00100,
		PH_READ_ACC  = 5'b01000,
		PH_READ_GYRO = 5'b10000
	} ipss_phase_t;

	// One unit of back-end work: an optional sample beat, then either a
	// two-byte register write or a seven-byte burst read.
	typedef struct packed {
		logic        has_sample;
		ipss_kind_t  sample_kind;
		logic [15:0] x_value;
		logic [15:0] y_value;
		logic [15:0] z_value;
		logic        is_write;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
	} ipss_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ipss_fifo_stat_t;

endpackage

// ----- rtl/ipss_in_if.sv -----
// ----------------------------------------------------------------------------
// ipss_in_if: input channel of the IMU SPI poll sequencer
// Valid/ready channel carrying a start event or one received byte.
// ----------------------------------------------------------------------------
interface ipss_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;

	modport source (output valid, output op, output rx_byte, input ready);
	modport sink (input valid, input op, input rx_byte, output ready);
endinterface

// ----- rtl/ipss_out_if.sv -----
// ----------------------------------------------------------------------------
// ipss_out_if: result channel of the IMU SPI poll sequencer
// Valid/ready channel carrying transmit bytes and X/Y/Z samples.
// ----------------------------------------------------------------------------
interface ipss_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [7:0]         tx_byte;
	logic signed [15:0] x_value;
	logic signed [15:0] y_value;
	logic signed [15:0] z_value;
	logic               last;

	modport source (output valid, output kind, output tx_byte, output x_value,
		output y_value, output z_value, output last, input ready);
	modport sink (input valid, input kind, input tx_byte, input x_value,
		input y_value, input z_value, input last, output ready);
endinterface

// ----- rtl/ipss_front.sv -----
// ----------------------------------------------------------------------------
// ipss_front: sequencing front end
// Accepts input beats, counts and stores reply bytes, steps the phase and
// turns each triggering beat into one command for the back end.
// ----------------------------------------------------------------------------
module ipss_front import ipss_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [1:0]      cfg_data,
	ipss_in_if.sink         events,
	output logic            push,
	output ipss_cmd_t       push_cmd,
	input  ipss_fifo_stat_t fifo_stat
);

	ipss_phase_t phase_q, phase_n;
	logic [2:0]  count_q, count_a, count_n;
	logic [7:0]  bytes_q [REPLY_BYTES];
	logic [7:0]  eff_bytes [REPLY_BYTES];
	logic [1:0]  accel_scale_q, gyro_scale_q;
	logic        fire, store, wr_byte, produce;
	logic [2:0]  wr_idx;
	logic [15:0] word_x, word_y, word_z;

	assign events.ready = !fifo_stat.full;
	assign fire         = events.valid && events.ready;
	assign store        = (events.op == OP_BYTE) && (count_q < REPLY_FULL);
	assign wr_byte      = store && (count_q != 3'd0);
	assign wr_idx       = count_q - 3'd1;
	assign count_a      = store ? count_q + 3'd1 : count_q;

	// The sixth reply byte may arrive in the same beat that completes the
	// burst, so the sample sees the incoming byte through a bypass.
	always_comb begin
		for (int i = 0; i < REPLY_BYTES; i++) begin
			eff_bytes[i] = (wr_byte && (wr_idx == 3'(i))) ? events.rx_byte : bytes_q[i];
		end
	end

	assign word_x = {eff_bytes[0], eff_bytes[1]};
	assign word_y = {eff_bytes[2], eff_bytes[3]};
	assign word_z = {eff_bytes[4], eff_bytes[5]};

	always_comb begin
		phase_n  = phase_q;
		count_n  = count_a;
		produce  = 1'b0;
		push_cmd = '0;
		unique case (phase_q)
			PH_INIT_ACC: begin
				phase_n           = PH_INIT_GYRO;
				produce           = 1'b1;
				push_cmd.is_write = 1'b1;
				push_cmd.byte0    = ACCEL_CFG_REG;
				push_cmd.byte1    = {3'b000, accel_scale_q, 3'b000};
			end
			PH_INIT_GYRO: begin
				if (count_a == WRITE_WAIT) begin
					phase_n           = PH_POLL_ACC;
					count_n           = 3'd0;
					produce           = 1'b1;
					push_cmd.is_write = 1'b1;
					push_cmd.byte0    = GYRO_CFG_REG;
					push_cmd.byte1    = {3'b000, gyro_scale_q, 3'b000};
				end
			end
			PH_POLL_ACC: begin
				if (count_a == WRITE_WAIT) begin
					phase_n        = PH_READ_ACC;
					count_n        = 3'd0;
					produce        = 1'b1;
					push_cmd.byte0 = READ_FLAG | ACCEL_DATA_REG;
				end
			end
			PH_READ_ACC: begin
				if (count_a == REPLY_FULL) begin
					phase_n              = PH_READ_GYRO;
					count_n              = 3'd0;
					produce              = 1'b1;
					push_cmd.has_sample  = 1'b1;
					push_cmd.sample_kind = KIND_ACCEL;
					push_cmd.x_value     = word_x;
					push_cmd.y_value     = word_y;
					push_cmd.z_value     = word_z;
					push_cmd.byte0       = READ_FLAG | GYRO_DATA_REG;
				end
			end
			PH_READ_GYRO: begin
				if (count_a == REPLY_FULL) begin
					phase_n              = PH_READ_ACC;
					count_n              = 3'd0;
					produce              = 1'b1;
					push_cmd.has_sample  = 1'b1;
					push_cmd.sample_kind = KIND_GYRO;
					push_cmd.x_value     = word_x;
					push_cmd.y_value     = word_y;
					push_cmd.z_value     = word_z;
					push_cmd.byte0       = READ_FLAG | ACCEL_DATA_REG;
				end
			end
			default: begin
			end
		endcase
	end

	assign push = fire && produce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_INIT_ACC;
			count_q       <= 3'd0;
			accel_scale_q <= 2'd0;
			gyro_scale_q  <= 2'd1;
		end else begin
			if (fire) begin
				phase_q <= phase_n;
				count_q <= count_n;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ACCEL_SCALE: accel_scale_q <= cfg_data;
					CFG_GYRO_SCALE:  gyro_scale_q  <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && wr_byte) begin
			bytes_q[wr_idx] <= events.rx_byte;
		end
	end

endmodule

// ----- rtl/ipss_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// ipss_cmd_fifo: command queue between front end and back end
// A short register queue so that input and output can stall independently.
// ----------------------------------------------------------------------------
module ipss_cmd_fifo import ipss_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ipss_cmd_t       push_cmd,
	input  logic            pop,
	output ipss_cmd_t       pop_cmd,
	output ipss_fifo_stat_t stat
);

	ipss_cmd_t              entries_q [CMD_FIFO_DEPTH];
	logic [CMD_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CMD_CNT_W-1:0]   count_q;

	assign stat.full  = (count_q == CMD_CNT_W'(CMD_FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_cmd    = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ?
					'0 : wr_ptr_q + CMD_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ?
					'0 : rd_ptr_q + CMD_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CMD_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CMD_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- rtl/ipss_back.sv -----
// ----------------------------------------------------------------------------
// ipss_back: result back end
// Expands each command into its result beats, one beat per clock while the
// registered output stage is free to take it.
// ----------------------------------------------------------------------------
module ipss_back import ipss_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  ipss_fifo_stat_t fifo_stat,
	output logic            pop,
	input  ipss_cmd_t       pop_cmd,
	ipss_out_if.source      results
);

	ipss_cmd_t   cmd_q;
	logic        active_q;
	logic [2:0]  beat_q, rel_beat;
	logic        slot_free, emit, sample_beat, beat_last;
	logic        out_valid_q, out_last_q;
	ipss_kind_t  out_kind_q, beat_kind;
	logic [7:0]  out_tx_q, beat_tx;
	logic [15:0] out_x_q, out_y_q, out_z_q, beat_x, beat_y, beat_z;

	assign slot_free   = !out_valid_q || results.ready;
	assign emit        = active_q && slot_free;
	assign rel_beat    = beat_q - {2'b00, cmd_q.has_sample};
	assign sample_beat = cmd_q.has_sample && (beat_q == 3'd0);
	assign beat_last   = !sample_beat &&
		(cmd_q.is_write ? (rel_beat == WRITE_LAST) : (rel_beat == READ_LAST));

	always_comb begin
		beat_kind = KIND_TX;
		beat_tx   = FILL_BYTE;
		beat_x    = '0;
		beat_y    = '0;
		beat_z    = '0;
		if (sample_beat) begin
			beat_kind = cmd_q.sample_kind;
			beat_x    = cmd_q.x_value;
			beat_y    = cmd_q.y_value;
			beat_z    = cmd_q.z_value;
		end else if (rel_beat == 3'd0) begin
			beat_tx = cmd_q.byte0;
		end else if (cmd_q.is_write) begin
			beat_tx = cmd_q.byte1;
		end
	end

	// Take the next command as the current one finishes, so commands run
	// back to back without a gap.
	assign pop = !fifo_stat.empty && (!active_q || (emit && beat_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			beat_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				beat_q   <= 3'd0;
			end else if (emit) begin
				beat_q <= beat_q + 3'd1;
				if (beat_last) begin
					active_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= pop_cmd;
		end
		if (emit) begin
			out_kind_q <= beat_kind;
			out_tx_q   <= beat_tx;
			out_x_q    <= beat_x;
			out_y_q    <= beat_y;
			out_z_q    <= beat_z;
			out_last_q <= beat_last;
		end
	end

	assign results.valid   = out_valid_q;
	assign results.kind    = out_kind_q;
	assign results.tx_byte = out_tx_q;
	assign results.x_value = out_x_q;
	assign results.y_value = out_y_q;
	assign results.z_value = out_z_q;
	assign results.last    = out_last_q;

endmodule

// ----- rtl/imu_spi_poll_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// imu_spi_poll_sequencer_unit: SPI poll sequencer for a six-axis motion sensor
// Top level: front end, command queue and back end.
// ----------------------------------------------------------------------------
// Each input beat is a start event or one byte received from the sensor. The
// block answers with runs of result beats: first a two-byte write of the
// accelerometer range, then, after two reply bytes, the gyro range write,
// then, after two more, an endless alternation of seven-byte burst reads of
// the acceleration and rotation registers. When a burst has returned its
// seven bytes the block emits one signed big-endian X/Y/Z sample followed by
// the seven bytes of the other read; the final beat caused by an input beat
// carries last. The front end takes one input beat per clock whenever the
// two-entry command queue has room, even while results are still waiting at
// the output. The back end drains one result beat per clock from its output
// register while the receiver is ready, and an input beat causes 2, 7 or 8
// result beats (none when it only counts a reply byte); the sustained rate is
// set by that output drain. Range registers are written through cfg_we,
// cfg_index and cfg_data and apply to the next write sent to the sensor.
// ----------------------------------------------------------------------------
module imu_spi_poll_sequencer_unit import ipss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [1:0] cfg_data,
	ipss_in_if.sink    events,
	ipss_out_if.source results
);

	logic            push, pop;
	ipss_cmd_t       push_cmd, pop_cmd;
	ipss_fifo_stat_t fifo_stat;

	// Front end: counts reply bytes, tracks the phase and builds commands.
	ipss_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.events    (events),
		.push      (push),
		.push_cmd  (push_cmd),
		.fifo_stat (fifo_stat)
	);

	// Two commands of slack let input and output stall independently.
	ipss_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.stat     (fifo_stat)
	);

	// Back end: expands each command into its beats.
	ipss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.pop_cmd   (pop_cmd),
		.results   (results)
	);

	// The front end must never write into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_stat.full)
		else $error("command pushed into a full queue");

	// The back end must never take a command from an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_stat.empty)
		else $error("command popped from an empty queue");

	// A sample is always followed by a burst read, so it is never the last beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && (results.kind != KIND_TX)) |-> !results.last)
		else $error("sample beat marked last");

	// Once a sample is taken, the read command byte follows in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.ready && (results.kind != KIND_TX)) |=>
		(results.valid && (results.kind == KIND_TX)))
		else $error("burst read does not follow a sample");

endmodule

// ----- verif/ipss_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipss_result_checker: scoreboard for the IMU SPI poll sequencer
// Watches the range register port and both channels. Each accepted input beat
// runs through a cycle-free copy of the sequencer, which queues the result
// beats it should cause. Each accepted result beat is compared field by field
// with the oldest queued beat.
// ----------------------------------------------------------------------------
module ipss_result_checker import ipss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [1:0] cfg_data,
	ipss_in_if         events,
	ipss_out_if        results,
	output int         fault_count,
	output int         pending_count
);

	typedef struct packed {
		ipss_kind_t         kind;
		logic [7:0]         tx_byte;
		logic signed [15:0] x_value;
		logic signed [15:0] y_value;
		logic signed [15:0] z_value;
		logic               last;
	} result_beat_t;

	result_beat_t expected_beats [$];
	result_beat_t oldest;
	int           faults;

	// Shadow of the sequencer state and of the range registers.
	ipss_phase_t  seq_phase;
	logic [2:0]   reply_count;
	logic [7:0]   reply_bytes [REPLY_BYTES];
	logic [1:0]   accel_scale;
	logic [1:0]   gyro_scale;

	task automatic queue_beat(input ipss_kind_t kind, input logic [7:0] tx,
			input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
		expected_beats.push_back('{kind, tx, x, y, z, 1'b0});
	endtask

	task automatic queue_write(input logic [7:0] reg_addr, input logic [1:0] code);
		queue_beat(KIND_TX, reg_addr, '0, '0, '0);
		queue_beat(KIND_TX, {3'b000, code, 3'b000}, '0, '0, '0);
	endtask

	// A burst read restarts the reply count; the first reply byte is dropped.
	task automatic queue_read(input logic [7:0] reg_addr);
		queue_beat(KIND_TX, READ_FLAG | reg_addr, '0, '0, '0);
		repeat (REPLY_BYTES) queue_beat(KIND_TX, FILL_BYTE, '0, '0, '0);
		reply_count = '0;
	endtask

	task automatic queue_sample(input ipss_kind_t kind);
		queue_beat(kind, '0, {reply_bytes[0], reply_bytes[1]},
			{reply_bytes[2], reply_bytes[3]}, {reply_bytes[4], reply_bytes[5]});
	endtask

	task automatic advance_sequence(input logic op, input logic [7:0] rx);
		int first;
		first = expected_beats.size();
		if (op == OP_BYTE && reply_count < REPLY_FULL) begin
			if (reply_count != 3'd0)
				reply_bytes[reply_count - 3'd1] = rx;
			reply_count = reply_count + 3'd1;
		end
		case (seq_phase)
			PH_INIT_ACC: begin
				seq_phase = PH_INIT_GYRO;
				queue_write(ACCEL_CFG_REG, accel_scale);
			end
			PH_INIT_GYRO: begin
				if (reply_count == WRITE_WAIT) begin
					seq_phase = PH_POLL_ACC;
					reply_count = '0;
					queue_write(GYRO_CFG_REG, gyro_scale);
				end
			end
			PH_POLL_ACC: begin
				if (reply_count == WRITE_WAIT) begin
					seq_phase = PH_READ_ACC;
					queue_read(ACCEL_DATA_REG);
				end
			end
			PH_READ_ACC: begin
				if (reply_count == REPLY_FULL) begin
					queue_sample(KIND_ACCEL);
					seq_phase = PH_READ_GYRO;
					queue_read(GYRO_DATA_REG);
				end
			end
			PH_READ_GYRO: begin
				if (reply_count == REPLY_FULL) begin
					queue_sample(KIND_GYRO);
					seq_phase = PH_READ_ACC;
					queue_read(ACCEL_DATA_REG);
				end
			end
			default: begin
			end
		endcase
		if (expected_beats.size() > first)
			expected_beats[expected_beats.size() - 1].last = 1'b1;
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			faults++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_beats.delete();
			faults = 0;
			seq_phase = PH_INIT_ACC;
			reply_count = '0;
			foreach (reply_bytes[i]) reply_bytes[i] = '0;
			accel_scale = 2'd0;
			gyro_scale = 2'd1;
			fault_count <= 0;
			pending_count <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ACCEL_SCALE)
					accel_scale = cfg_data;
				else
					gyro_scale = cfg_data;
			end
			// Results go first: no beat can leave on the edge its cause arrives.
			if (results.valid && results.ready) begin
				if (expected_beats.size() == 0) begin
					$display("%0t: result beat with nothing expected: kind %h tx %h last %b",
						$time, results.kind, results.tx_byte, results.last);
					faults++;
				end else begin
					oldest = expected_beats.pop_front();
					check_field("kind", 16'(oldest.kind), 16'(results.kind));
					check_field("tx_byte", 16'(oldest.tx_byte), 16'(results.tx_byte));
					check_field("x_value", oldest.x_value, results.x_value);
					check_field("y_value", oldest.y_value, results.y_value);
					check_field("z_value", oldest.z_value, results.z_value);
					check_field("last", 16'(oldest.last), 16'(results.last));
				end
			end
			if (events.valid && events.ready)
				advance_sequence(events.op, events.rx_byte);
			fault_count <= faults;
			pending_count <= expected_beats.size();
		end
	end

endmodule

// ----- verif/imu_spi_poll_sequencer_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_spi_poll_sequencer_unit_test: regression bench of the SPI poll sequencer
// Drives start events and reply bytes into the sequencer, programs the range
// registers between phases, and applies sender gaps and receiver stalls at
// several rates. A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module imu_spi_poll_sequencer_unit_test;
	import ipss_pkg::*;

	localparam int PHASE_BYTES   = 100;     // reply bytes per random phase
	localparam int SETTLE_CYCLES = 20;      // covers the front end and queue
	localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
	localparam int CYCLE_LIMIT   = 400000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = CFG_ACCEL_SCALE;
	logic [1:0] cfg_data = 2'd0;

	int         fault_count;
	int         pending_count;
	int         src_idle_pct = 0;
	int         sink_stall_pct = 0;
	int         hold_seq = 0;
	int         hold_done = 0;
	int         cycle_count = 0;
	int         sent_bytes;

	ipss_in_if  ev_ch ();
	ipss_out_if res_ch ();

	imu_spi_poll_sequencer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.events   (ev_ch),
		.results  (res_ch)
	);

	ipss_result_checker checker_u (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.events       (ev_ch),
		.results      (res_ch),
		.fault_count  (fault_count),
		.pending_count(pending_count)
	);

	always #10 clk = ~clk;

	// Global watchdog. The slowest legal run stays far below this limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("imu_spi_poll_sequencer_unit regression: fail");
			$finish;
		end
	end

	// Result receiver. It stalls at the current rate, and whenever the stimulus
	// asks for a hold-off it keeps ready low for a long, counted stretch so that
	// the command queue fills and the input side has to wait.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seq != hold_done) begin
				hold_done = hold_seq;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Offers one beat, after a random gap, and returns at the edge where it is
	// taken. Valid is left high so that a following beat needs no new assignment
	// in the same time step; whoever stops sending lowers it.
	task automatic send_beat(input logic op, input logic [7:0] rx);
		while ($urandom_range(99) < src_idle_pct) begin
			ev_ch.valid <= 1'b0;
			@(posedge clk);
		end
		ev_ch.valid <= 1'b1;
		ev_ch.op <= op;
		ev_ch.rx_byte <= rx;
		do @(posedge clk); while (!ev_ch.ready);
	endtask

	// Stops sending until every predicted beat has come out. A reply byte that
	// causes no result may still be in flight, hence the settling time.
	task automatic drain_results();
		ev_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the accelerometer range register, then the gyro range register.
	// Only called while the block is idle.
	task automatic write_ranges(input logic [1:0] accel_code, input logic [1:0] gyro_code);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ACCEL_SCALE;
		cfg_data <= accel_code;
		@(posedge clk);
		cfg_index <= CFG_GYRO_SCALE;
		cfg_data <= gyro_code;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		ev_ch.valid <= 1'b0;
		ev_ch.op <= OP_START;
		ev_ch.rx_byte <= 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The accelerometer write takes the top range code; the
		// reply byte that comes with the first item already counts toward the
		// wait of the gyro write.
		write_ranges(2'd3, 2'd2);
		send_beat(OP_BYTE, 8'hA5);
		// A start event mid-sequence adds nothing while the count is short.
		send_beat(OP_START, 8'hFF);
		drain_results();
		// A range change between the writes shows up in the gyro write only.
		write_ranges(2'd0, 2'd3);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_START, 8'h00);
		send_beat(OP_BYTE, 8'hFF);
		send_beat(OP_BYTE, 8'h5A);
		// Acceleration burst: dropped byte, then full negative, full positive
		// and minus one.
		send_beat(OP_BYTE, 8'h11);
		send_beat(OP_BYTE, 8'h80);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_BYTE, 8'h7F);
		send_beat(OP_BYTE, 8'hFF);
		send_beat(OP_BYTE, 8'hFF);
		send_beat(OP_BYTE, 8'hFF);
		// Rotation burst with a start event in the middle of the reply.
		send_beat(OP_BYTE, 8'h22);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_START, 8'hC3);
		send_beat(OP_BYTE, 8'h00);
		send_beat(OP_BYTE, 8'h01);
		send_beat(OP_BYTE, 8'hFF);
		send_beat(OP_BYTE, 8'h00);
		drain_results();

		// Random part, in four phases of pacing. Almost every beat is a reply
		// byte with random content, which keeps the burst reads cycling; a few
		// start events are mixed in as noise.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_ranges(2'd1, 2'd0);
					src_idle_pct <= 0;
					sink_stall_pct <= 0;
					// Long receiver hold-off while beats keep coming at full rate.
					hold_seq <= hold_seq + 1;
				end
				1: begin
					write_ranges(2'd2, 2'd1);
					src_idle_pct <= 48;
					sink_stall_pct <= 0;
				end
				2: begin
					write_ranges(2'd0, 2'd2);
					src_idle_pct <= 0;
					sink_stall_pct <= 48;
				end
				default: begin
					write_ranges(2'd3, 2'd3);
					src_idle_pct <= 38;
					sink_stall_pct <= 38;
				end
			endcase
			sent_bytes = 0;
			while (sent_bytes < PHASE_BYTES) begin
				if ($urandom_range(9) == 0) begin
					send_beat(OP_START, 8'($urandom));
				end else begin
					send_beat(OP_BYTE, 8'($urandom));
					sent_bytes++;
				end
				// Now and then the sender waits for the output to run dry.
				if ($urandom_range(99) == 0)
					drain_results();
			end
			drain_results();
		end

		if (fault_count == 0 && pending_count == 0) begin
			$display("imu_spi_poll_sequencer_unit regression: pass");
		end else begin
			$display("imu_spi_poll_sequencer_unit regression: fail");
		end
		$finish;
	end

endmodule
